>>> sv/alsd_pkg.sv
package alsd_pkg;

   // ring of repeated readings that must all agree before a switch state change
   localparam int REPEAT_COUNT = 8;
   localparam int RING_PTR_W   = $clog2(REPEAT_COUNT);

   // switches on the ladder; switch 0 means nothing pressed
   localparam int NUM_SWITCHES = 6;
   localparam int NUM_WINDOWS  = NUM_SWITCHES - 1;

   // result queue, counted in input transactions (each holds up to two results)
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // command codes
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // event kinds
   localparam logic [2:0] KIND_RELEASED = 3'd0;
   localparam logic [2:0] KIND_PRESSED  = 3'd1;
   localparam logic [2:0] KIND_DONE     = 3'd2;
   localparam logic [2:0] KIND_FAILED   = 3'd3;
   localparam logic [2:0] KIND_REPLY    = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_WINDOW_DELTA   = 2'd0;
   localparam logic [1:0] CSR_NONE_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_FAILSAFE_LIMIT = 2'd2;

   // register reset values
   localparam logic [9:0]  WINDOW_DELTA_RST   = 10'd150;
   localparam logic [11:0] NONE_THRESHOLD_RST = 12'd3800;
   localparam logic [7:0]  FAILSAFE_LIMIT_RST = 8'd40;

   // window centres for switches 1 to 5, tried in this order
   localparam logic [11:0] WINDOW_CENTRE [NUM_WINDOWS] =
      '{12'd2048, 12'd2730, 12'd3413, 12'd1365, 12'd683};

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] id;
   } result_type;

   // everything one input transaction reports
   typedef struct packed {
      result_type  res0;
      result_type  res1;
      logic        two;
      logic [31:0] dur;
      logic [NUM_SWITCHES-1:0] mask;
   } entry_type;

endpackage

>>> sv/analog_ladder_switch_decoder.sv
// Six-switch resistor ladder decoder.
// Request channel (req_*): a command with an ADC sample, a millisecond time and a
// switch select. Start opens a scan, samples are classified into a ring of
// REPEAT_COUNT readings, and when all readings agree the pressed flags change and
// release then press events go out; no change gives a done result, an exhausted
// attempt budget a failed result. A query returns the held duration of a switch.
// Response channel (rsp_*): one result per transaction, rsp_last on the final
// result caused by a request. Configuration (csr_*): always ready; the user is
// to write it only while the block is idle, which the block does not enforce.
// Timing: a request is processed in the cycle it is accepted; its results are
// registered in the result queue. Throughput: one request per cycle unless the
// queue is full, bounded by the response port, which delivers one result per
// cycle (a request with both a release and a press gives two results).
// Reset: synchronous, clears the scan, pressed flags and the result queue and
// restores the register defaults.
// Stall: results wait in a two-transaction queue; req_stall rises when it is full.
module analog_ladder_switch_decoder
   import alsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_sample,
   input  logic [31:0] req_now_ms,
   input  logic [2:0]  req_switch_sel,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [2:0]  rsp_switch_id,
   output logic [31:0] rsp_duration_ms,
   output logic [5:0]  rsp_pressed_mask,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   // configuration registers
   logic [9:0]  window_delta_ff;
   logic [11:0] none_threshold_ff;
   logic [7:0]  failsafe_limit_ff;

   // scan state
   logic [2:0]            ring_ff       [REPEAT_COUNT];
   logic [2:0]            ring_in       [REPEAT_COUNT];
   logic [REPEAT_COUNT-1:0] ring_valid_ff, ring_valid_in;
   logic [RING_PTR_W-1:0] ring_ptr_ff, ring_ptr_in;
   logic [7:0]            attempts_ff, attempts_in;
   logic                  scanning_ff, scanning_in;
   logic [NUM_SWITCHES-1:0] flags_ff, flags_in;
   logic [31:0]           stamp_ff [NUM_SWITCHES];
   logic [NUM_SWITCHES-1:0] stamp_we;

   // result queue
   entry_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    q_wr_ff, q_rd_ff;
   logic [Q_CNT_W-1:0]    q_cnt_ff;
   logic                  sub_ff;

   // datapath signals
   logic                  accept;
   logic                  push;
   entry_type             entry;
   logic [12:0]           win_lo [NUM_WINDOWS];
   logic [12:0]           win_hi [NUM_WINDOWS];
   logic [NUM_WINDOWS-1:0] in_win;
   logic                  sw_valid;
   logic [2:0]            sw;
   logic                  ring_wr;
   logic                  settled;
   logic [NUM_SWITCHES-1:0] new_flags, rel, prs;
   logic [2:0]            rel_id, prs_id;
   logic [7:0]            att_dec;
   entry_type             head;
   logic                  head_last;
   logic                  pop_result;
   logic                  pop_entry;

   assign csr_ready = 1'b1;
   assign accept    = req_valid & ~req_stall;
   assign req_stall = (q_cnt_ff == Q_CNT_W'(Q_DEPTH));

   // window edges, lower edge clamped at zero
   always_comb begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
         win_lo[i] = ({2'b0, window_delta_ff} > WINDOW_CENTRE[i]) ? 13'd0 :
                     {1'b0, WINDOW_CENTRE[i] - {2'b0, window_delta_ff}};
         win_hi[i] = {1'b0, WINDOW_CENTRE[i]} + {3'b0, window_delta_ff};
         in_win[i] = ({1'b0, req_sample} >= win_lo[i]) &&
                     ({1'b0, req_sample} <= win_hi[i]);
      end
   end

   // sample classification, first matching window wins
   always_comb begin
      sw_valid = 1'b0;
      sw       = 3'd0;
      if (req_sample > none_threshold_ff) begin
         sw_valid = 1'b1;
      end else begin
         for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
            if (in_win[i]) begin
               sw_valid = 1'b1;
               sw       = 3'(i + 1);
            end
         end
         if (!sw_valid && req_sample <= {2'b0, window_delta_ff}) begin
            sw_valid = 1'b1;
            sw       = 3'(NUM_SWITCHES);
         end
      end
   end

   // ring write and agreement check
   assign ring_wr = (req_cmd == CMD_SAMPLE) && scanning_ff && sw_valid;

   always_comb begin
      ring_valid_in = ring_valid_ff;
      settled       = 1'b1;
      for (int i = 0; i < REPEAT_COUNT; i++) begin
         ring_in[i] = ring_ff[i];
         if (ring_wr && ring_ptr_ff == RING_PTR_W'(i)) begin
            ring_in[i]       = sw;
            ring_valid_in[i] = 1'b1;
         end
      end
      for (int i = 0; i < REPEAT_COUNT; i++) begin
         if (!ring_valid_in[i] || ring_in[i] != ring_in[0]) begin
            settled = 1'b0;
         end
      end
   end

   // flag changes for a settled reading
   always_comb begin
      rel_id = 3'd0;
      prs_id = 3'd0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
         new_flags[i] = (ring_in[0] == 3'(i + 1));
      end
      rel = flags_ff & ~new_flags;
      prs = new_flags & ~flags_ff;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
         if (rel[i]) rel_id = 3'(i + 1);
         if (prs[i]) prs_id = 3'(i + 1);
      end
   end

   assign att_dec = (attempts_ff != 8'd0) ? attempts_ff - 8'd1 : attempts_ff;

   // command handling
   always_comb begin
      ring_ptr_in = ring_ptr_ff;
      attempts_in = attempts_ff;
      scanning_in = scanning_ff;
      flags_in    = flags_ff;
      stamp_we    = '0;
      push        = 1'b0;
      entry       = '{res0: '{kind: KIND_FAILED, id: 3'd0},
                      res1: '{kind: KIND_FAILED, id: 3'd0},
                      two: 1'b0, dur: 32'd0, mask: flags_ff};
      case (req_cmd)
         CMD_START: begin
            if (!scanning_ff) begin
               ring_ptr_in = '0;
               if (failsafe_limit_ff <= 8'd1) begin
                  attempts_in = 8'd0;
                  push        = 1'b1;
               end else begin
                  attempts_in = failsafe_limit_ff - 8'd1;
                  scanning_in = 1'b1;
               end
            end
         end
         CMD_SAMPLE: begin
            if (scanning_ff) begin
               if (ring_wr) begin
                  ring_ptr_in = (ring_ptr_ff == RING_PTR_W'(REPEAT_COUNT - 1)) ? '0 :
                                ring_ptr_ff + RING_PTR_W'(1);
               end
               if (settled) begin
                  scanning_in = 1'b0;
                  flags_in    = new_flags;
                  stamp_we    = rel | prs;
                  push        = 1'b1;
                  entry.mask  = new_flags;
                  if (rel == '0 && prs == '0) begin
                     entry.res0 = '{kind: KIND_DONE, id: 3'd0};
                  end else if (rel != '0) begin
                     entry.res0 = '{kind: KIND_RELEASED, id: rel_id};
                     entry.res1 = '{kind: KIND_PRESSED, id: prs_id};
                     entry.two  = (prs != '0);
                  end else begin
                     entry.res0 = '{kind: KIND_PRESSED, id: prs_id};
                  end
               end else begin
                  attempts_in = att_dec;
                  if (att_dec == 8'd0) begin
                     scanning_in = 1'b0;
                     push        = 1'b1;
                  end
               end
            end
         end
         CMD_QUERY: begin
            push = 1'b1;
            entry.res0.kind = KIND_REPLY;
            if (req_switch_sel >= 3'd1 && req_switch_sel <= 3'(NUM_SWITCHES)) begin
               entry.res0.id = req_switch_sel;
               if (flags_ff[req_switch_sel - 3'd1]) begin
                  entry.dur = req_now_ms - stamp_ff[req_switch_sel - 3'd1];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_delta_ff   <= WINDOW_DELTA_RST;
         none_threshold_ff <= NONE_THRESHOLD_RST;
         failsafe_limit_ff <= FAILSAFE_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_DELTA:   window_delta_ff   <= csr_data[9:0];
            CSR_NONE_THRESHOLD: none_threshold_ff <= csr_data;
            CSR_FAILSAFE_LIMIT: failsafe_limit_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // scan control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         ring_ptr_ff   <= '0;
         attempts_ff   <= 8'd0;
         scanning_ff   <= 1'b0;
         flags_ff      <= '0;
      end else if (accept) begin
         if (req_cmd == CMD_START && !scanning_ff) begin
            ring_valid_ff <= '0;
         end else begin
            ring_valid_ff <= ring_valid_in;
         end
         ring_ptr_ff <= ring_ptr_in;
         attempts_ff <= attempts_in;
         scanning_ff <= scanning_in;
         flags_ff    <= flags_in;
      end
   end

   // ring readings and press timestamps
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < REPEAT_COUNT; i++) begin
            ring_ff[i] <= ring_in[i];
         end
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (stamp_we[i]) stamp_ff[i] <= req_now_ms;
         end
      end
   end

   // result queue read side
   assign head       = q_ff[q_rd_ff];
   assign rsp_valid  = (q_cnt_ff != '0);
   assign head_last  = ~head.two | sub_ff;
   assign pop_result = rsp_valid & ~rsp_stall;
   assign pop_entry  = pop_result & head_last;

   assign rsp_event_kind   = sub_ff ? head.res1.kind : head.res0.kind;
   assign rsp_switch_id    = sub_ff ? head.res1.id : head.res0.id;
   assign rsp_duration_ms  = head.dur;
   assign rsp_pressed_mask = head.mask;
   assign rsp_last         = head_last;

   // result queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
         sub_ff   <= 1'b0;
      end else begin
         if (accept && push) begin
            q_wr_ff <= (q_wr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_wr_ff + Q_PTR_W'(1);
         end
         if (pop_entry) begin
            q_rd_ff <= (q_rd_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_rd_ff + Q_PTR_W'(1);
         end
         if (pop_result) begin
            sub_ff <= ~head_last;
         end
         q_cnt_ff <= q_cnt_ff + Q_CNT_W'(accept && push) - Q_CNT_W'(pop_entry);
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (accept && push) begin
         q_ff[q_wr_ff] <= entry;
      end
   end

endmodule
